// ----- rtl/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_DATA = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] data;
  } lkv_out_t;

  typedef struct packed {
    logic upd;
    logic sel;
    logic wr_key;
    logic wr_data;
  } lkv_cell_cmd_t;

endpackage

// ----- rtl/lkv_entry.sv -----
// One cache entry: key and data storage, key compare and recency rank update.
module lkv_entry import lkv_pkg::*; #(
  parameter int unsigned RANK_W = 4,
  parameter int unsigned OCC_W  = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  lkv_cell_cmd_t       cmd_i,
  input  logic [DATA_W-1:0]   key_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [OCC_W-1:0]    thresh_i,
  output logic                match_o,
  output logic [DATA_W-1:0]   data_o,
  output logic [RANK_W-1:0]   rank_o
);

  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  always_comb begin
    key_d  = cmd_i.wr_key  ? key_i   : key_q;
    data_d = cmd_i.wr_data ? value_i : data_q;
    rank_d = rank_q;
    if (cmd_i.upd) begin
      if (cmd_i.sel) begin
        rank_d = '0;
      end else if (valid_i && (OCC_W'(rank_q) < thresh_i)) begin
        rank_d = rank_q + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  assign match_o = valid_i && (key_q == key_i);
  assign data_o  = data_q;
  assign rank_o  = rank_q;

endmodule

// ----- rtl/lru_key_value_cache_core.sv -----
// Fully associative LRU key-value cache, top level.
// A get item is held in the input register, and its result in the result register;
// a set gives no result.
// Throughput: one item per cycle; all entries compare in parallel. A get in the
// input register stalls the input while an earlier result waits unaccepted.
// Reset empties the cache (occupancy zero, ranks zero) and sets capacity to 16.
module lru_key_value_cache_core import lkv_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lkv_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lkv_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic             in_valid_q, in_valid_d;
  lkv_in_t          in_q, in_d;
  logic             out_valid_q, out_valid_d;
  lkv_out_t         out_q, out_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  logic                    proc;
  logic                    is_get;
  logic [MAX_ENTRIES-1:0]  valid_w;
  logic [MAX_ENTRIES-1:0]  match_w;
  logic [MAX_ENTRIES-1:0]  victim_w;
  logic [DATA_W-1:0]       data_w [MAX_ENTRIES];
  logic [RANK_W-1:0]       rank_w [MAX_ENTRIES];
  lkv_cell_cmd_t           cmd_w  [MAX_ENTRIES];
  logic                    hit;
  logic [DATA_W-1:0]       hit_data;
  logic [RANK_W-1:0]       hit_rank;
  logic [CMP_W-1:0]        cap_ext;
  logic [CMP_W-1:0]        eff_cap;
  logic                    full;
  logic [OCC_W-1:0]        occ_last;
  logic [OCC_W-1:0]        thresh;

  assign is_get      = (in_q.func == FUNC_GET);
  assign proc        = in_valid_q && (!is_get || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || proc;
  assign cfg_ready_o = 1'b1;
  assign occ_last    = occ_q - OCC_W'(1);

  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full = (CMP_W'(occ_q) >= eff_cap);
  end

  always_comb begin
    hit_data = '0;
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_w[i]  = (OCC_W'(i) < occ_q);
      victim_w[i] = valid_w[i] && (OCC_W'(rank_w[i]) == occ_last);
      hit_data    = hit_data | (data_w[i] & {DATA_W{match_w[i]}});
      hit_rank    = hit_rank | (rank_w[i] & {RANK_W{match_w[i]}});
    end
    hit = |match_w;
  end

  always_comb begin
    thresh = '0;
    occ_d  = occ_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cmd_w[i] = '0;
    end
    if (proc) begin
      if (is_get) begin
        thresh = OCC_W'(hit_rank);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          cmd_w[i].upd = hit;
          cmd_w[i].sel = match_w[i];
        end
      end else if (hit) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          cmd_w[i].wr_data = match_w[i];
        end
      end else if (full) begin
        thresh = occ_last;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          cmd_w[i].upd     = 1'b1;
          cmd_w[i].sel     = victim_w[i];
          cmd_w[i].wr_key  = victim_w[i];
          cmd_w[i].wr_data = victim_w[i];
        end
      end else begin
        thresh = occ_q;
        occ_d  = occ_q + OCC_W'(1);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          cmd_w[i].upd     = 1'b1;
          cmd_w[i].sel     = (OCC_W'(i) == occ_q);
          cmd_w[i].wr_key  = (OCC_W'(i) == occ_q);
          cmd_w[i].wr_data = (OCC_W'(i) == occ_q);
        end
      end
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_entry
    lkv_entry #(
      .RANK_W (RANK_W),
      .OCC_W  (OCC_W)
    ) u_entry (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_w[g]),
      .cmd_i    (cmd_w[g]),
      .key_i    (in_q.key),
      .value_i  (in_q.value),
      .thresh_i (thresh),
      .match_o  (match_w[g]),
      .data_o   (data_w[g]),
      .rank_o   (rank_w[g])
    );
  end

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      in_d       = in_data_i;
    end
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (proc && is_get) begin
      out_valid_d = 1'b1;
      out_d.hit   = hit;
      out_d.data  = hit ? hit_data : MISS_DATA;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    cap_d = cfg_valid_i ? cfg_data_i : cap_q;
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cap_q       <= cap_d;
      occ_q       <= occ_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> $onehot0(match_w))
    else $error("more than one entry matches the key");

  a_victim_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !is_get && !hit && full) |-> $onehot(victim_w))
    else $error("eviction needs exactly one least recent entry");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(occ_q) <= CMP_W'(MAX_ENTRIES))
    else $error("occupancy above entry count");

  a_set_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !is_get && out_valid_q && out_ready_i) |=> !out_valid_q)
    else $error("set item produced a result");

endmodule

// ----- tb/sv/lru_cache_checker.sv -----
`timescale 1ns / 1ps
// Checker for the LRU key-value cache: mirrors the entries and compares every lookup result.
module lru_cache_checker import lkv_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  lkv_in_t          in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  lkv_out_t         out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o,
  output int unsigned      lookups_o,
  output int unsigned      hits_o
);

  logic              slot_used [SLOTS];
  logic [DATA_W-1:0] slot_key  [SLOTS];
  logic [DATA_W-1:0] slot_val  [SLOTS];
  int unsigned       slot_age  [SLOTS];
  int unsigned       fill;
  logic [CAP_W-1:0]  capacity;
  lkv_out_t          awaited_lookups [$];
  int unsigned       mismatch_count = 0;
  int unsigned       pending_count = 0;
  int unsigned       lookup_count = 0;
  int unsigned       hit_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;
  assign lookups_o    = lookup_count;
  assign hits_o       = hit_count;

  function automatic int unsigned capacity_limit();
    if (capacity == '0) return 1;
    if (capacity > SLOTS) return SLOTS;
    return capacity;
  endfunction

  function automatic void make_newest(int s);
    int unsigned r;
    int i;
    r = slot_age[s];
    for (i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && i != s && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Apply one item to the mirror; returns 1 when the item yields a lookup result.
  function automatic bit cache_access(input lkv_in_t item, output lkv_out_t res);
    int hit_slot;
    int victim;
    int free_slot;
    int i;
    hit_slot  = -1;
    victim    = -1;
    free_slot = -1;
    res.hit   = 1'b0;
    res.data  = MISS_DATA;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == item.key && hit_slot < 0) hit_slot = i;
    end
    if (item.func == FUNC_GET) begin
      if (hit_slot >= 0) begin
        make_newest(hit_slot);
        res.hit  = 1'b1;
        res.data = slot_val[hit_slot];
      end
      return 1'b1;
    end
    if (hit_slot >= 0) begin
      slot_val[hit_slot] = item.value;
      return 1'b0;
    end
    if (fill >= capacity_limit() || fill >= SLOTS) begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      end
      if (victim >= 0) begin
        slot_key[victim] = item.key;
        slot_val[victim] = item.value;
        make_newest(victim);
      end
      return 1'b0;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    if (free_slot >= 0) begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) slot_age[i]++;
      end
      slot_used[free_slot] = 1'b1;
      slot_key[free_slot]  = item.key;
      slot_val[free_slot]  = item.value;
      slot_age[free_slot]  = 0;
      fill++;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string detail);
    if (mismatch_count < 40) $display("%0t ns: mismatch: %s", $time, detail);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lkv_out_t got;
    lkv_out_t want;
    int i;
    if (!rst_ni) begin
      for (i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      fill     = 0;
      capacity = CAP_RESET;
      awaited_lookups.delete();
      pending_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (awaited_lookups.size() == 0) begin
          report_mismatch($sformatf("result hit %0b data %h with no lookup pending",
                                    got.hit, got.data));
        end else begin
          want = awaited_lookups.pop_front();
          lookup_count++;
          if (want.hit) hit_count++;
          if (got.hit !== want.hit) begin
            report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
          end
          if (got.data !== want.data) begin
            report_mismatch($sformatf("data %h, expected %h", got.data, want.data));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cache_access(in_data_i, want)) awaited_lookups.push_back(want);
      end
      pending_count = awaited_lookups.size();
    end
  end

endmodule

// ----- tb/sv/lru_key_value_cache_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the LRU key-value cache: stimulus, idling schedule and verdict.
module lru_key_value_cache_core_tb;
  import lkv_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned POOL        = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  lkv_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  lkv_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned lookups;
  int unsigned hits;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned cycles;
  int unsigned gets_sent;
  int unsigned sets_sent;
  int unsigned cfg_writes;
  logic [DATA_W-1:0] key_pool [POOL];

  lru_key_value_cache_core #(.MAX_ENTRIES(SLOTS)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  lru_cache_checker #(.SLOTS(SLOTS)) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .lookups_o   (lookups),
    .hits_o      (hits)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("lru_key_value_cache_core_tb NOT OK");
      $finish;
    end
  end

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_op(input logic f, input logic [DATA_W-1:0] k,
                         input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, key: k, value: v};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (f == FUNC_GET) gets_sent++;
    else sets_sent++;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_segment(input logic [CAP_W-1:0] c, input int unsigned n);
    int unsigned eff;
    int unsigned span;
    logic f;
    logic [DATA_W-1:0] k;
    write_capacity(c);
    eff = (c == '0) ? 1 : ((c > SLOTS) ? SLOTS : c);
    repeat (n) begin
      span = $urandom_range(POOL, eff + 1);
      f = ($urandom_range(99) < 50) ? FUNC_SET : FUNC_GET;
      k = ($urandom_range(99) < 15) ? $urandom() : key_pool[$urandom_range(span - 1)];
      send_op(f, k, $urandom());
    end
  endtask

  initial begin
    int unsigned caps [9] = '{4, 6, 9, 12, 16, 20, 5, 1, 16};
    int i;
    int p;
    int s;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    cycles        = 0;
    gets_sent     = 0;
    sets_sent     = 0;
    cfg_writes    = 0;
    src_idle_pct  = 9;
    sink_idle_pct = 75;
    for (i = 0; i < POOL; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = '1;
    key_pool[3] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // capacity zero acts as one: second insert replaces the first
    write_capacity(5'd0);
    send_op(FUNC_GET, 32'h0000_0000, 32'h1234_5678);
    send_op(FUNC_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_op(FUNC_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_op(FUNC_GET, 32'h8000_0000, '0);
    send_op(FUNC_GET, 32'h7fff_ffff, '1);
    // oversized capacity saturates
    write_capacity(5'd31);
    send_op(FUNC_SET, '1, '1);
    send_op(FUNC_SET, '0, '0);
    send_op(FUNC_GET, '1, '0);
    send_op(FUNC_SET, '0, 32'h0000_0005);
    send_op(FUNC_GET, '0, '0);
    send_op(FUNC_GET, 32'h7fff_ffff, '0);
    send_op(FUNC_GET, 32'h0000_0001, '0);
    // capacity below occupancy: replace in place
    write_capacity(5'd2);
    send_op(FUNC_SET, 32'h0000_0001, 32'h0000_0001);
    send_op(FUNC_GET, '1, '0);
    send_op(FUNC_GET, '0, '0);
    send_op(FUNC_GET, 32'h0000_0001, '0);
    send_op(FUNC_GET, 32'h7fff_ffff, '0);

    for (p = 0; p < 3; p++) begin
      src_idle_pct  = (p == 0) ? 9 : ((p == 1) ? 75 : 0);
      sink_idle_pct = (p == 0) ? 75 : ((p == 1) ? 9 : 0);
      for (s = 0; s < 3; s++) run_segment(CAP_W'(caps[p * 3 + s]), 144);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("sent %0d items (%0d gets, %0d sets) under %0d capacity settings",
             gets_sent + sets_sent, gets_sent, sets_sent, cfg_writes);
    $display("compared %0d lookup results, %0d of them hits", lookups, hits);
    if (mismatches == 0 && pending == 0) begin
      $display("lru_key_value_cache_core_tb OK");
    end else begin
      $display("lru_key_value_cache_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lkv_pkg.sv
rtl/lkv_entry.sv
rtl/lru_key_value_cache_core.sv
tb/sv/lru_cache_checker.sv
tb/sv/lru_key_value_cache_core_tb.sv
